// ===== rtl/inpr_pkg.sv =====
// package for the indexed node pool: sizes, opcodes, command and state types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package inpr_pkg;
    localparam int POOL_NODES   = 1024;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = 10;
    localparam int DATA_W       = 32;
    localparam int NODE_W       = $clog2(POOL_NODES);
    localparam int PAY_W        = PAYLOAD_BITS;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_LINK    = 3'd1,
        OP_UNLINK  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_LINK,
        K_UNLINK,
        K_RELEASE,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   node;
        logic [IDX_W-1:0]   root;
        logic [PAY_W-1:0]   data;
        logic               node_ok;
        logic               root_ok;
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_L_RD,
        S_L_W1,
        S_L_W2,
        S_U_RD,
        S_U_W1,
        S_U_W2,
        S_REL,
        S_REP_RD,
        S_REP_OUT
    } state_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } status_t;

    function automatic logic node_in_pool(input logic [IDX_W-1:0] i);
        return (i != '0) && (32'(i) < POOL_NODES);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/inpr_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module inpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/inpr_front.sv =====
// front end: accepts input items and classifies them into commands
// depends on inpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module inpr_front (
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [2:0]             opcode,
    input  wire logic [inpr_pkg::IDX_W-1:0]  node_index,
    input  wire logic [inpr_pkg::IDX_W-1:0]  root_index,
    input  wire logic [inpr_pkg::DATA_W-1:0] payload,
    input  wire inpr_pkg::status_t      status,
    input  wire logic                   q_full,
    output logic                        q_push,
    output inpr_pkg::cmd_t              q_cmd
);
    import inpr_pkg::*;

    always_comb
    begin
        in_stall = q_full || status.clearing;
        q_push   = in_valid && !in_stall;
        unique case (opcode)
            OP_ALLOC:   q_cmd.kind = K_ALLOC;
            OP_LINK:    q_cmd.kind = K_LINK;
            OP_UNLINK:  q_cmd.kind = K_UNLINK;
            OP_RELEASE: q_cmd.kind = K_RELEASE;
            default:    q_cmd.kind = K_READ;
        endcase
        q_cmd.node    = node_index;
        q_cmd.root    = root_index;
        q_cmd.data    = PAY_W'(payload);
        q_cmd.node_ok = node_in_pool(node_index);
        q_cmd.root_ok = node_in_pool(root_index);
    end
endmodule
`default_nettype wire

// ===== rtl/inpr_queue.sv =====
// two entry command queue between front and back
// depends on inpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module inpr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire inpr_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output inpr_pkg::cmd_t      head_cmd,
    output logic                empty,
    output logic                full
);
    import inpr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign head_cmd = slot_reg[rptr_reg];
    assign empty    = (cnt_reg == 2'd0);
    assign full     = (cnt_reg == 2'd2);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/inpr_back.sv =====
// back end: sequencer over the payload and link rams, plus the result register
// depends on inpr_pkg and inpr_ram
`timescale 1ns / 1ps
`default_nettype none
module inpr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire inpr_pkg::cmd_t head_cmd,
    input  wire logic           q_empty,
    output logic                q_pop,
    output inpr_pkg::status_t   status,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [inpr_pkg::IDX_W-1:0]  result_index,
    output logic [inpr_pkg::IDX_W-1:0]  next_of_node,
    output logic [inpr_pkg::IDX_W-1:0]  prev_of_node,
    output logic [inpr_pkg::DATA_W-1:0] node_payload,
    output logic                pool_full
);
    import inpr_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [NODE_W-1:0]  scan_reg, scan_next;
    logic [NODE_W-1:0]  pos_reg, pos_next;
    logic [NODE_W-1:0]  tries_reg, tries_next;
    logic [NODE_W-1:0]  clr_reg, clr_next;
    logic [NODE_W-1:0]  m_reg, m_next;
    logic [NODE_W-1:0]  rep_reg, rep_next;
    logic [IDX_W-1:0]   res_reg, res_next;
    logic               ov_reg, ov_next;
    logic [IDX_W-1:0]   ri_reg, ri_next, nx_reg, nx_next, pv_reg, pv_next;
    logic [DATA_W-1:0]  pl_reg, pl_next;
    logic               pf_reg, pf_next;

    logic               pay_we, nxt_we, prv_we;
    logic [NODE_W-1:0]  pay_wa, nxt_wa, prv_wa, pay_ra, nxt_ra, prv_ra;
    logic [PAY_W-1:0]   pay_wd, pay_rd;
    logic [NODE_W-1:0]  nxt_wd, prv_wd, nxt_rd, prv_rd;
    logic [NODE_W-1:0]  node_a, root_a;

    inpr_ram #(.WIDTH(PAY_W), .DEPTH(POOL_NODES)) u_pay (
        .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(pay_wd),
        .raddr(pay_ra), .rdata(pay_rd)
    );
    inpr_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(nxt_ra), .rdata(nxt_rd)
    );
    inpr_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_prv (
        .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(prv_ra), .rdata(prv_rd)
    );

    assign node_a          = NODE_W'(cmd_reg.node);
    assign root_a          = NODE_W'(cmd_reg.root);
    assign status.clearing = (state_reg == S_CLR);
    assign status.busy     = (state_reg != S_IDLE);
    assign out_valid       = ov_reg;
    assign result_index    = ri_reg;
    assign next_of_node    = nx_reg;
    assign prev_of_node    = pv_reg;
    assign node_payload    = pl_reg;
    assign pool_full       = pf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            scan_reg  <= NODE_W'(1);
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        tries_reg <= tries_next;
        m_reg     <= m_next;
        rep_reg   <= rep_next;
        res_reg   <= res_next;
        ri_reg    <= ri_next;
        nx_reg    <= nx_next;
        pv_reg    <= pv_next;
        pl_reg    <= pl_next;
        pf_reg    <= pf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        scan_next  = scan_reg;
        pos_next   = pos_reg;
        tries_next = tries_reg;
        clr_next   = clr_reg;
        m_next     = m_reg;
        rep_next   = rep_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && out_stall;
        ri_next    = ri_reg;
        nx_next    = nx_reg;
        pv_next    = pv_reg;
        pl_next    = pl_reg;
        pf_next    = pf_reg;
        q_pop      = 1'b0;
        pay_we = 1'b0; pay_wa = '0; pay_wd = '0; pay_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = '0;

        unique case (state_reg)
            S_CLR:
            begin
                pay_we   = 1'b1;
                pay_wa   = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
                if (32'(clr_reg) == POOL_NODES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty && !ov_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = head_cmd;
                    rep_next = NODE_W'(head_cmd.node);
                    res_next = head_cmd.node;
                    if (head_cmd.kind == K_ALLOC)
                    begin
                        pos_next   = scan_reg;
                        tries_next = '0;
                        state_next = S_A_RD;
                    end
                    else if (!head_cmd.node_ok)
                    begin
                        ov_next = 1'b1;
                        ri_next = head_cmd.node;
                        nx_next = '0;
                        pv_next = '0;
                        pl_next = '0;
                        pf_next = 1'b0;
                    end
                    else
                    begin
                        case (head_cmd.kind)
                            K_LINK:    state_next = head_cmd.root_ok ? S_L_RD : S_REP_RD;
                            K_UNLINK:  state_next = S_U_RD;
                            K_RELEASE: state_next = S_REL;
                            default:   state_next = S_REP_RD;
                        endcase
                    end
                end
            end
            S_A_RD:
            begin
                pay_ra     = pos_reg;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (pay_rd == '0)
                begin
                    pay_we = 1'b1; pay_wa = pos_reg; pay_wd = cmd_reg.data;
                    nxt_we = 1'b1; nxt_wa = pos_reg; nxt_wd = pos_reg;
                    prv_we = 1'b1; prv_wa = pos_reg; prv_wd = pos_reg;
                    scan_next  = (32'(pos_reg) == POOL_NODES - 1) ? NODE_W'(1)
                                                                 : pos_reg + NODE_W'(1);
                    rep_next   = pos_reg;
                    res_next   = IDX_W'(pos_reg);
                    state_next = S_REP_RD;
                end
                else if (32'(tries_reg) == POOL_NODES - 2)
                begin
                    ov_next    = 1'b1;
                    ri_next    = '0;
                    nx_next    = '0;
                    pv_next    = '0;
                    pl_next    = '0;
                    pf_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    tries_next = tries_reg + NODE_W'(1);
                    pos_next   = (32'(pos_reg) == POOL_NODES - 1) ? NODE_W'(1)
                                                                 : pos_reg + NODE_W'(1);
                    state_next = S_A_RD;
                end
            end
            S_L_RD:
            begin
                nxt_ra     = root_a;
                state_next = S_L_W1;
            end
            S_L_W1:
            begin
                m_next = nxt_rd;
                prv_we = 1'b1; prv_wa = node_a; prv_wd = root_a;
                nxt_we = 1'b1; nxt_wa = node_a; nxt_wd = nxt_rd;
                state_next = S_L_W2;
            end
            S_L_W2:
            begin
                nxt_we = 1'b1; nxt_wa = root_a; nxt_wd = node_a;
                prv_we = (32'(m_reg) < POOL_NODES);
                prv_wa = m_reg; prv_wd = node_a;
                state_next = S_REP_RD;
            end
            S_U_RD:
            begin
                nxt_ra     = node_a;
                prv_ra     = node_a;
                state_next = S_U_W1;
            end
            S_U_W1:
            begin
                prv_we = (32'(nxt_rd) < POOL_NODES);
                prv_wa = nxt_rd; prv_wd = prv_rd;
                nxt_we = (32'(prv_rd) < POOL_NODES);
                nxt_wa = prv_rd; nxt_wd = nxt_rd;
                state_next = S_U_W2;
            end
            S_U_W2:
            begin
                nxt_we = 1'b1; nxt_wa = node_a; nxt_wd = node_a;
                prv_we = 1'b1; prv_wa = node_a; prv_wd = node_a;
                state_next = S_REP_RD;
            end
            S_REL:
            begin
                pay_we     = 1'b1;
                pay_wa     = node_a;
                state_next = S_REP_RD;
            end
            S_REP_RD:
            begin
                pay_ra     = rep_reg;
                nxt_ra     = rep_reg;
                prv_ra     = rep_reg;
                state_next = S_REP_OUT;
            end
            S_REP_OUT:
            begin
                ov_next    = 1'b1;
                ri_next    = res_reg;
                nx_next    = IDX_W'(nxt_rd);
                pv_next    = IDX_W'(prv_rd);
                pl_next    = DATA_W'(pay_rd);
                pf_next    = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/indexed_node_pool_with_rings.sv =====
// top level of the indexed node pool with doubly linked rings
// depends on inpr_pkg, inpr_front, inpr_queue, inpr_back
// a bad node index is reported straight from idle; allocate probes nodes in turn for a zero
// payload and reports pool_full when none of them is free
// throughput: one item in flight in the back sequencer, two queued ahead
// reset: a clearing pass zeroes every payload ram entry, input stalls meanwhile
`timescale 1ns / 1ps
`default_nettype none
module indexed_node_pool_with_rings (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  opcode,
    input  wire logic [inpr_pkg::IDX_W-1:0]  node_index,
    input  wire logic [inpr_pkg::IDX_W-1:0]  root_index,
    input  wire logic [inpr_pkg::DATA_W-1:0] payload,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [inpr_pkg::IDX_W-1:0]       result_index,
    output logic [inpr_pkg::IDX_W-1:0]       next_of_node,
    output logic [inpr_pkg::IDX_W-1:0]       prev_of_node,
    output logic [inpr_pkg::DATA_W-1:0]      node_payload,
    output logic                             pool_full
);
    import inpr_pkg::*;

    status_t status;
    cmd_t    push_cmd, head_cmd;
    logic    q_push, q_pop, q_empty, q_full;

    inpr_front u_front (
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .node_index(node_index), .root_index(root_index), .payload(payload),
        .status(status), .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
    );

    inpr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(push_cmd),
        .pop(q_pop), .head_cmd(head_cmd), .empty(q_empty), .full(q_full)
    );

    inpr_back u_back (
        .clk(clk), .rst_n(rst_n), .head_cmd(head_cmd), .q_empty(q_empty),
        .q_pop(q_pop), .status(status), .out_valid(out_valid),
        .out_stall(out_stall), .result_index(result_index),
        .next_of_node(next_of_node), .prev_of_node(prev_of_node),
        .node_payload(node_payload), .pool_full(pool_full)
    );

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> in_stall)
        else $error("item accepted during clearing pass");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pool_full |-> result_index == '0 && node_payload == '0)
        else $error("full result carries data");

    a_null_node: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_index == '0 |-> next_of_node == '0 && prev_of_node == '0)
        else $error("node zero reported with links");
endmodule
`default_nettype wire

// ===== tb/sv/tb_pool_checker.sv =====
// checker for the indexed node pool: watches both channels, predicts each result
// from its own copy of the pool and compares in order; depends on inpr_pkg
`timescale 1ns / 1ps
module tb_pool_checker
    import inpr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [2:0]        opcode,
    input  wire logic [IDX_W-1:0]  node_index,
    input  wire logic [IDX_W-1:0]  root_index,
    input  wire logic [DATA_W-1:0] payload,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [IDX_W-1:0]  result_index,
    input  wire logic [IDX_W-1:0]  next_of_node,
    input  wire logic [IDX_W-1:0]  prev_of_node,
    input  wire logic [DATA_W-1:0] node_payload,
    input  wire logic              pool_full,
    output int                     fails,
    output int                     pending
);
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  nxt;
        logic [IDX_W-1:0]  prv;
        logic [DATA_W-1:0] pay;
        logic              full;
    } node_report_t;

    logic [PAY_W-1:0] pool_pay [POOL_NODES];
    logic [IDX_W-1:0] pool_nxt [POOL_NODES];
    logic [IDX_W-1:0] pool_prv [POOL_NODES];
    logic [IDX_W-1:0] scan_pos;
    node_report_t     reports_due [$];

    assign pending = reports_due.size();

    function automatic logic in_range(input logic [IDX_W-1:0] i);
        return (i != '0) && (int'(i) < POOL_NODES);
    endfunction

    function automatic node_report_t describe(input logic [IDX_W-1:0] i, input logic full);
        node_report_t r;
        r = '0;
        r.idx  = i;
        r.full = full;
        if (in_range(i))
        begin
            r.nxt = pool_nxt[i];
            r.prv = pool_prv[i];
            r.pay = DATA_W'(pool_pay[i]);
        end
        return r;
    endfunction

    task automatic pool_apply(input logic [2:0] op, input logic [IDX_W-1:0] x,
                              input logic [IDX_W-1:0] r, input logic [DATA_W-1:0] d,
                              output node_report_t res);
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] m;
        logic [IDX_W-1:0] p;
        int               tries;
        logic             found;
        pos   = in_range(scan_pos) ? scan_pos : IDX_W'(1);
        found = 1'b0;
        if (op == OP_ALLOC)
        begin
            res = describe('0, 1'b1);
            for (tries = 0; tries < POOL_NODES - 1 && !found; tries++)
            begin
                if (pool_pay[pos] == '0)
                begin
                    found = 1'b1;
                    pool_pay[pos] = PAY_W'(d);
                    pool_nxt[pos] = pos;
                    pool_prv[pos] = pos;
                    scan_pos = (int'(pos) + 1 >= POOL_NODES) ? IDX_W'(1) : pos + 1'b1;
                    res = describe(pos, 1'b0);
                end
                else
                    pos = (int'(pos) + 1 >= POOL_NODES) ? IDX_W'(1) : pos + 1'b1;
            end
        end
        else
        begin
            if (in_range(x))
            begin
                case (op)
                    OP_LINK:
                    begin
                        if (in_range(r))
                        begin
                            m = pool_nxt[r];
                            pool_prv[x] = r;
                            pool_nxt[x] = m;
                            pool_nxt[r] = x;
                            pool_prv[m] = x;
                        end
                    end
                    OP_UNLINK:
                    begin
                        m = pool_nxt[x];
                        p = pool_prv[x];
                        pool_prv[m] = p;
                        pool_nxt[p] = m;
                        pool_nxt[x] = x;
                        pool_prv[x] = x;
                    end
                    OP_RELEASE: pool_pay[x] = '0;
                    default: ;
                endcase
            end
            res = describe(x, 1'b0);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        node_report_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_NODES; i++)
            begin
                pool_pay[i] = '0;
                pool_nxt[i] = '0;
                pool_prv[i] = '0;
            end
            scan_pos = IDX_W'(1);
            reports_due.delete();
            fails = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                    report_mismatch("unexpected item, index", DATA_W'(result_index), '0);
                else
                begin
                    e = reports_due.pop_front();
                    if (result_index !== e.idx)
                        report_mismatch("result_index", DATA_W'(result_index), DATA_W'(e.idx));
                    if (next_of_node !== e.nxt)
                        report_mismatch("next_of_node", DATA_W'(next_of_node), DATA_W'(e.nxt));
                    if (prev_of_node !== e.prv)
                        report_mismatch("prev_of_node", DATA_W'(prev_of_node), DATA_W'(e.prv));
                    if (node_payload !== e.pay)
                        report_mismatch("node_payload", node_payload, e.pay);
                    if (pool_full !== e.full)
                        report_mismatch("pool_full", DATA_W'(pool_full), DATA_W'(e.full));
                end
            end
            if (in_valid && !in_stall)
            begin
                pool_apply(opcode, node_index, root_index, payload, e);
                reports_due.push_back(e);
            end
        end
    end
endmodule

// ===== tb/sv/tb_indexed_node_pool_with_rings.sv =====
// testbench top for indexed_node_pool_with_rings: directed items,
// then random ring traffic with random idling; depends on inpr_pkg and tb_pool_checker
`timescale 1ns / 1ps
module tb_indexed_node_pool_with_rings;
    import inpr_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        opcode = '0;
    logic [IDX_W-1:0]  node_index = '0;
    logic [IDX_W-1:0]  root_index = '0;
    logic [DATA_W-1:0] payload = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [IDX_W-1:0]  result_index;
    logic [IDX_W-1:0]  next_of_node;
    logic [IDX_W-1:0]  prev_of_node;
    logic [DATA_W-1:0] node_payload;
    logic              pool_full;
    int                fails;
    int                pending;
    logic              idle_on = 1'b1;
    logic              hold_go = 1'b0;
    int                quiet_cycles = 0;
    logic              linked_ok [POOL_NODES];
    logic [IDX_W-1:0]  linked_list [$];

    always #4 clk = ~clk;

    indexed_node_pool_with_rings u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .node_index(node_index), .root_index(root_index), .payload(payload),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_index(result_index), .next_of_node(next_of_node),
        .prev_of_node(prev_of_node), .node_payload(node_payload), .pool_full(pool_full)
    );

    tb_pool_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .node_index(node_index), .root_index(root_index), .payload(payload),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_index(result_index), .next_of_node(next_of_node),
        .prev_of_node(prev_of_node), .node_payload(node_payload), .pool_full(pool_full),
        .fails(fails), .pending(pending)
    );

    // nodes whose links are known written
    initial
        for (int i = 0; i < POOL_NODES; i++)
            linked_ok[i] = 1'b0;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall && result_index != '0 && !linked_ok[result_index])
        begin
            linked_ok[result_index] = 1'b1;
            linked_list.push_back(result_index);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0)
            begin
                out_stall = 1'b1;
                hold_cnt--;
            end
            else
                out_stall = idle_on && ($urandom_range(0, 99) < 31);
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [IDX_W-1:0] x,
                             input logic [IDX_W-1:0] r, input logic [DATA_W-1:0] d);
        while (idle_on && $urandom_range(0, 99) < 31)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode     = op;
        node_index = x;
        root_index = r;
        payload    = d;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_node();
        if (linked_list.size() == 0)
            return '0;
        return linked_list[$urandom_range(0, linked_list.size() - 1)];
    endfunction

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int               w;
        logic [2:0]       op;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] r;
        logic [DATA_W-1:0] d;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_ALLOC, '0, '0, 32'hffff_ffff);
        send_item(OP_ALLOC, 10'h3ff, 10'h3ff, '0);
        send_item(OP_ALLOC, '0, '0, 32'h1);
        send_item(OP_LINK, 10'd2, 10'd1, '0);
        send_item(OP_LINK, 10'd3, 10'd1, '0);
        send_item(OP_READ, 10'd1, '0, '0);
        send_item(OP_UNLINK, 10'd2, '0, '0);
        send_item(OP_LINK, 10'd1, '0, '0);
        send_item(OP_LINK, '0, 10'd1, '0);
        send_item(OP_UNLINK, '0, '0, '0);
        send_item(OP_RELEASE, '0, '0, '0);
        send_item(OP_RELEASE, 10'd3, '0, '0);
        send_item(3'd5, 10'd1, '0, '0);
        send_item(3'd6, '0, '0, '0);
        send_item(3'd7, 10'd3, '0, '0);
        send_item(OP_UNLINK, 10'd1, '0, '0);
        send_item(OP_READ, 10'd2, '0, '0);
        wait_drained();

        // random traffic
        for (int i = 0; i < 430; i++)
        begin
            if (i == 100)
                hold_go = 1'b1;
            if (i == 300)
                wait_drained();
            idle_on = !(i >= 200 && i < 280);
            w = $urandom_range(0, 99);
            x = pick_node();
            r = pick_node();
            d = $urandom;
            if (w < 22)
            begin
                op = OP_ALLOC;
                x  = IDX_W'($urandom);
                r  = IDX_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    d = '0;
            end
            else if (w < 42)
                op = OP_LINK;
            else if (w < 57)
                op = OP_UNLINK;
            else if (w < 80)
                op = OP_RELEASE;
            else if (w < 90)
                op = OP_READ;
            else if (w < 94)
                op = 3'($urandom_range(5, 7));
            else
            begin
                op = 3'($urandom_range(1, 7));
                if ($urandom_range(0, 1) == 0)
                    x = '0;
                else
                    r = '0;
            end
            send_item(op, x, r, d);
        end
        in_valid = 1'b0;
        idle_on  = 1'b1;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
